[sv/rk4h_pkg.sv]
// rk4h_pkg: shared types, constants and the microcode table of the rk4 oscillator step.
// No dependencies; imported by rk4h_dp and rk4_harmonic_oscillator_step.
`default_nettype none

package rk4h_pkg;

	// fixed q-format and rounding constants of the slope combine
	localparam int                 DIV6_SHIFT = 28;
	localparam logic signed [30:0] DIV6_MUL   = 31'sd44739243;
	localparam logic signed [63:0] K_MAX      = (64'sd1 <<< 33) - 64'sd1;
	localparam logic signed [63:0] K_MIN      = -(64'sd1 <<< 33);

	// microcode addresses
	localparam int            UA_W      = 5;
	localparam logic [4:0]    UA_DONE   = 5'd16;
	localparam logic [4:0]    UA_LOAD   = 5'd17;

	typedef struct packed {
		logic               func;
		logic signed [31:0] load_position;
		logic signed [31:0] load_velocity;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic               saturated;
	} res_t;

	typedef enum logic [2:0] {
		MS_NONE,
		MS_VEL_MID,
		MS_POS_MID_NEG,
		MS_ACC_P,
		MS_ACC_V
	} mul_src_t;

	typedef enum logic [1:0] {
		RN_NONE,
		RN_SLOPE,
		RN_DIV6
	} rnd_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_P,
		WB_V,
		WB_FIN_P,
		WB_FIN_V,
		WB_LOAD
	} wb_t;

	typedef enum logic [1:0] {
		PH_K1,
		PH_K2,
		PH_K3,
		PH_K4
	} phase_t;

	typedef enum logic [1:0] {
		SQ_NEXT,
		SQ_JUMP,
		SQ_BR_LOAD,
		SQ_DONE
	} seq_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} fsm_t;

	typedef struct packed {
		mul_src_t   mul;
		rnd_t       rnd;
		wb_t        wb;
		phase_t     phase;
		seq_t       seq;
		logic [4:0] target;
	} uop_t;

	localparam uop_t UOP_NOP = '{MS_NONE, RN_NONE, WB_NONE, PH_K1, SQ_NEXT, 5'd0};

	// multiply issue, round and write-back overlap; a rounded product is held in k and read by the next word's write-back
	function automatic uop_t uc_rom(input logic [4:0] addr);
		uop_t w;
		begin
			unique case (addr)
				5'd0:  w = '{MS_VEL_MID,     RN_NONE,  WB_NONE,  PH_K1, SQ_BR_LOAD, UA_LOAD};
				5'd1:  w = '{MS_POS_MID_NEG, RN_SLOPE, WB_NONE,  PH_K1, SQ_NEXT,    5'd0};
				5'd2:  w = '{MS_NONE,        RN_SLOPE, WB_P,     PH_K1, SQ_NEXT,    5'd0};
				5'd3:  w = '{MS_POS_MID_NEG, RN_NONE,  WB_V,     PH_K1, SQ_NEXT,    5'd0};
				5'd4:  w = '{MS_VEL_MID,     RN_SLOPE, WB_NONE,  PH_K2, SQ_NEXT,    5'd0};
				5'd5:  w = '{MS_NONE,        RN_SLOPE, WB_V,     PH_K2, SQ_NEXT,    5'd0};
				5'd6:  w = '{MS_VEL_MID,     RN_NONE,  WB_P,     PH_K2, SQ_NEXT,    5'd0};
				5'd7:  w = '{MS_POS_MID_NEG, RN_SLOPE, WB_NONE,  PH_K3, SQ_NEXT,    5'd0};
				5'd8:  w = '{MS_NONE,        RN_SLOPE, WB_P,     PH_K3, SQ_NEXT,    5'd0};
				5'd9:  w = '{MS_POS_MID_NEG, RN_NONE,  WB_V,     PH_K3, SQ_NEXT,    5'd0};
				5'd10: w = '{MS_VEL_MID,     RN_SLOPE, WB_NONE,  PH_K4, SQ_NEXT,    5'd0};
				5'd11: w = '{MS_NONE,        RN_SLOPE, WB_V,     PH_K4, SQ_NEXT,    5'd0};
				5'd12: w = '{MS_ACC_V,       RN_NONE,  WB_P,     PH_K4, SQ_NEXT,    5'd0};
				5'd13: w = '{MS_ACC_P,       RN_DIV6,  WB_NONE,  PH_K4, SQ_NEXT,    5'd0};
				5'd14: w = '{MS_NONE,        RN_DIV6,  WB_FIN_V, PH_K4, SQ_NEXT,    5'd0};
				5'd15: w = '{MS_NONE,        RN_NONE,  WB_FIN_P, PH_K4, SQ_NEXT,    5'd0};
				5'd16: w = '{MS_NONE,        RN_NONE,  WB_NONE,  PH_K1, SQ_DONE,    5'd0};
				5'd17: w = '{MS_NONE,        RN_NONE,  WB_LOAD,  PH_K1, SQ_JUMP,    UA_DONE};
				default: w = UOP_NOP;
			endcase
			return w;
		end
	endfunction

endpackage

`default_nettype wire

[sv/rk4h_dp.sv]
// rk4h_dp: datapath of the oscillator step: one shared multiplier, rounding, slope accumulate.
// Driven one control word per cycle; depends on rk4h_pkg.
`default_nettype none

module rk4h_dp
	import rk4h_pkg::*;
#(
	parameter int FRAC_BITS = 29
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire uop_t               ctl,
	input  wire logic               start,
	input  wire logic [29:0]        step_size,
	input  wire logic signed [31:0] load_position,
	input  wire logic signed [31:0] load_velocity,
	output logic signed [31:0]      position,
	output logic signed [31:0]      velocity,
	output logic                    saturated
);

	localparam logic signed [63:0] RND_SL  = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] RND_D6  = 64'sd1 <<< (DIV6_SHIFT - 1);
	localparam logic signed [31:0] VEL_RST = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [37:0] W_MAX   = 38'sd2147483647;
	localparam logic signed [37:0] W_MIN   = -38'sd2147483648;

	logic signed [31:0] p_q, v_q, mp_q, mv_q;
	logic signed [36:0] acc_p_q, acc_v_q;
	logic signed [63:0] prod_q;
	logic signed [35:0] k_q;
	logic               clip_q;

	logic signed [30:0] a_op;
	logic signed [36:0] b_op;
	logic signed [67:0] prod;

	logic signed [63:0] sl_t, sl_r, d6_t, d6_r;
	logic               sl_hi, sl_lo, rnd_clip;
	logic signed [35:0] k_next;

	logic               wb_pos, wb_fin, wb_mid;
	logic signed [37:0] k38, y38, acc38, acc_new, off38, sum38;
	logic signed [31:0] sum_sat;
	logic               sum_hi, sum_lo, wb_clip;

	// shared multiplier: step size times a state value, or the divide-by-six reciprocal
	always_comb begin
		case (ctl.mul)
			MS_VEL_MID:     b_op = {{5{mv_q[31]}}, mv_q};
			MS_POS_MID_NEG: b_op = -{{5{mp_q[31]}}, mp_q};
			MS_ACC_P:       b_op = acc_p_q;
			MS_ACC_V:       b_op = acc_v_q;
			default:        b_op = '0;
		endcase
		if (ctl.mul == MS_ACC_P || ctl.mul == MS_ACC_V)
			a_op = DIV6_MUL;
		else
			a_op = {1'b0, step_size};
		prod = a_op * b_op;
	end

	// rounding: floor shifts are arithmetic shifts
	always_comb begin
		sl_t  = prod_q + RND_SL;
		sl_r  = sl_t >>> FRAC_BITS;
		d6_t  = prod_q + RND_D6;
		d6_r  = d6_t >>> DIV6_SHIFT;
		sl_hi = sl_r > K_MAX;
		sl_lo = sl_r < K_MIN;
		rnd_clip = 1'b0;
		k_next   = k_q;
		case (ctl.rnd)
			RN_SLOPE: begin
				rnd_clip = sl_hi | sl_lo;
				if (sl_hi)
					k_next = K_MAX[35:0];
				else if (sl_lo)
					k_next = K_MIN[35:0];
				else
					k_next = sl_r[35:0];
			end
			RN_DIV6: k_next = d6_r[35:0];
			default: k_next = k_q;
		endcase
	end

	// write-back: accumulate the weighted slope and form the next midpoint or final value
	always_comb begin
		wb_pos = (ctl.wb == WB_P) || (ctl.wb == WB_FIN_P);
		wb_fin = (ctl.wb == WB_FIN_P) || (ctl.wb == WB_FIN_V);
		wb_mid = ((ctl.wb == WB_P) || (ctl.wb == WB_V)) && (ctl.phase != PH_K4);
		k38    = {{2{k_q[35]}}, k_q};
		y38    = wb_pos ? {{6{p_q[31]}}, p_q} : {{6{v_q[31]}}, v_q};
		acc38  = wb_pos ? {acc_p_q[36], acc_p_q} : {acc_v_q[36], acc_v_q};
		case (ctl.phase)
			PH_K1:   acc_new = k38;
			PH_K4:   acc_new = acc38 + k38;
			default: acc_new = acc38 + (k38 <<< 1);
		endcase
		case (ctl.phase)
			PH_K1, PH_K2: off38 = (k38 + 38'sd1) >>> 1;
			default:      off38 = k38;
		endcase
		sum38  = y38 + off38;
		sum_hi = sum38 > W_MAX;
		sum_lo = sum38 < W_MIN;
		if (sum_hi)
			sum_sat = W_MAX[31:0];
		else if (sum_lo)
			sum_sat = W_MIN[31:0];
		else
			sum_sat = sum38[31:0];
		wb_clip = (wb_mid | wb_fin) & (sum_hi | sum_lo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q    <= '0;
			v_q    <= VEL_RST;
			clip_q <= 1'b0;
		end else begin
			if (ctl.wb == WB_LOAD) begin
				p_q <= load_position;
				v_q <= load_velocity;
			end else if (ctl.wb == WB_FIN_P) begin
				p_q <= sum_sat;
			end else if (ctl.wb == WB_FIN_V) begin
				v_q <= sum_sat;
			end
			if (start)
				clip_q <= 1'b0;
			else if (rnd_clip | wb_clip)
				clip_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul != MS_NONE)
			prod_q <= prod[63:0];
		k_q <= k_next;
		if (start) begin
			mp_q <= p_q;
			mv_q <= v_q;
		end else if (wb_mid) begin
			if (wb_pos)
				mp_q <= sum_sat;
			else
				mv_q <= sum_sat;
		end
		if (ctl.wb == WB_P)
			acc_p_q <= acc_new[36:0];
		if (ctl.wb == WB_V)
			acc_v_q <= acc_new[36:0];
	end

	assign position  = p_q;
	assign velocity  = v_q;
	assign saturated = clip_q;

endmodule

`default_nettype wire

[sv/rk4_harmonic_oscillator_step.sv]
// rk4_harmonic_oscillator_step: top level, handshakes, step-size register and microcode sequencer.
// Depends on rk4h_pkg and rk4h_dp.
//
//  channel  dir  handshake            payload
//  cmd      in   cmd_valid/cmd_ready  cmd_t: func, load_position, load_velocity
//  res      out  res_valid/res_ready  res_t: position, velocity, saturated
//  cfg      in   cfg_we               cfg_wdata: step_size, 30 bits
//
// an advance runs 17 microcode words on the shared multiplier; the done word registers the result
// and returns to idle, where the next cmd is taken; a load goes from word 0 to the load word, then
// to done; the eight dependent slope multiplies and the final combine set the program length
// reset: position 0, velocity 1.0, step size 0.1; no clearing pass
// a finished result waits in the res register while the next cmd is taken; the sequencer
// holds on its last word only if that register is still occupied and not being read out
`default_nettype none

module rk4_harmonic_oscillator_step
	import rk4h_pkg::*;
#(
	parameter int FRAC_BITS = 29
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	input  wire cmd_t        cmd,
	output logic             res_valid,
	input  wire logic        res_ready,
	output res_t             res,
	input  wire logic        cfg_we,
	input  wire logic [29:0] cfg_wdata
);

	localparam longint unsigned STEP_RST_L = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
	localparam logic [29:0]     STEP_RST   = STEP_RST_L[29:0];

	fsm_t             state_q, state_d;
	logic [UA_W-1:0]  pc_q, pc_d;
	logic [29:0]      step_q;
	cmd_t             cmd_q;
	res_t             res_q;
	logic             res_valid_q;
	uop_t             uop, uop_run;
	logic             cmd_xfer, res_xfer, fire;
	logic signed [31:0] dp_pos, dp_vel;
	logic             dp_sat;

	assign uop      = uc_rom(pc_q);
	assign cmd_xfer = cmd_valid & cmd_ready;
	assign res_xfer = res_valid_q & res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		cmd_ready = 1'b0;
		fire      = 1'b0;
		uop_run   = UOP_NOP;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = ST_RUN;
					pc_d    = '0;
				end
			end
			ST_RUN: begin
				uop_run = uop;
				unique case (uop.seq)
					SQ_NEXT:    pc_d = pc_q + 5'd1;
					SQ_JUMP:    pc_d = uop.target;
					SQ_BR_LOAD: pc_d = cmd_q.func ? uop.target : pc_q + 5'd1;
					SQ_DONE: begin
						// hold until the res register is free
						if (!res_valid_q || res_ready) begin
							fire    = 1'b1;
							state_d = ST_IDLE;
						end
					end
					default: pc_d = pc_q;
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				step_q <= cfg_wdata;
			if (fire)
				res_valid_q <= 1'b1;
			else if (res_xfer)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer)
			cmd_q <= cmd;
		if (fire)
			res_q <= '{position: dp_pos, velocity: dp_vel, saturated: dp_sat};
	end

	rk4h_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (uop_run),
		.start        (cmd_xfer),
		.step_size    (step_q),
		.load_position(cmd_q.load_position),
		.load_velocity(cmd_q.load_velocity),
		.position     (dp_pos),
		.velocity     (dp_vel),
		.saturated    (dp_sat)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_xfer_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |=> (state_q == ST_RUN && pc_q == '0))
		else $error("cmd transfer did not start the program at word 0");

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> pc_q <= UA_LOAD)
		else $error("microcode address ran past the program");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && uop.seq == SQ_DONE && res_valid_q && !res_ready)
		|=> (state_q == ST_RUN && $stable(pc_q) && res_valid_q))
		else $error("result finished over an occupied res register");

	a_fire_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (res_valid_q && state_q == ST_IDLE))
		else $error("finished item not presented");

endmodule

`default_nettype wire

[tb/rk4_harmonic_oscillator_step_tb.sv]
// rk4_harmonic_oscillator_step_tb: self-checking bench for the rk4 oscillator step block.
// Needs rk4h_pkg and the rk4_harmonic_oscillator_step rtl; predicts every state update
// in 64-bit integer math and checks the returned state under bursty traffic and stalls.
`timescale 1ns / 100ps

module rk4_harmonic_oscillator_step_tb;
	import rk4h_pkg::*;

	localparam int   FRAC         = 29;
	localparam logic FUNC_ADVANCE = 1'b0;
	localparam logic FUNC_LOAD    = 1'b1;
	localparam logic [29:0] STEP_RESET = 30'd53687091;
	localparam longint W_HI = 64'sd2147483647;
	localparam longint W_LO = -64'sd2147483648;
	localparam int   HOLD_CYCLES  = 250;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	cmd_t        cmd = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_t        res;
	logic        cfg_we = 1'b0;
	logic [29:0] cfg_wdata = '0;

	rk4_harmonic_oscillator_step DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// model of the oscillator state and the step size register
	logic signed [31:0] pos_model = 32'sd0;
	logic signed [31:0] vel_model = 32'sd1 <<< FRAC;
	logic [29:0]        step_model = STEP_RESET;
	bit                 clip_seen;

	cmd_t cmd_backlog[$];
	res_t expected_states[$];
	int   errors = 0;
	int   results_seen = 0;

	function automatic longint clamp(input longint x, input longint lo, input longint hi);
		if (x > hi) begin
			clip_seen = 1'b1;
			return hi;
		end
		if (x < lo) begin
			clip_seen = 1'b1;
			return lo;
		end
		return x;
	endfunction

	// h * a with round half up, then limited to 34 bits
	function automatic longint slope(input longint a);
		longint prod;
		prod = longint'(step_model) * a;
		return clamp((prod + (64'sd1 <<< (FRAC - 1))) >>> FRAC, K_MIN, K_MAX);
	endfunction

	function automatic longint div6(input longint s);
		return (s * longint'(DIV6_MUL) + (64'sd1 <<< (DIV6_SHIFT - 1))) >>> DIV6_SHIFT;
	endfunction

	function automatic res_t next_state(input cmd_t c);
		longint p, v, mp, mv;
		longint k1p, k1v, k2p, k2v, k3p, k3v, k4p, k4v;
		res_t r;
		p = longint'(pos_model);
		v = longint'(vel_model);
		clip_seen = 1'b0;
		if (c.func == FUNC_LOAD) begin
			pos_model = c.load_position;
			vel_model = c.load_velocity;
		end else begin
			k1p = slope(v);
			k1v = slope(-p);
			mp  = clamp(p + ((k1p + 1) >>> 1), W_LO, W_HI);
			mv  = clamp(v + ((k1v + 1) >>> 1), W_LO, W_HI);
			k2p = slope(mv);
			k2v = slope(-mp);
			mp  = clamp(p + ((k2p + 1) >>> 1), W_LO, W_HI);
			mv  = clamp(v + ((k2v + 1) >>> 1), W_LO, W_HI);
			k3p = slope(mv);
			k3v = slope(-mp);
			mp  = clamp(p + k3p, W_LO, W_HI);
			mv  = clamp(v + k3v, W_LO, W_HI);
			k4p = slope(mv);
			k4v = slope(-mp);
			pos_model = 32'(clamp(p + div6(k1p + 2 * k2p + 2 * k3p + k4p), W_LO, W_HI));
			vel_model = 32'(clamp(v + div6(k1v + 2 * k2v + 2 * k3v + k4v), W_LO, W_HI));
		end
		r.position  = pos_model;
		r.velocity  = vel_model;
		r.saturated = clip_seen;
		return r;
	endfunction

	function automatic cmd_t load_cmd(input logic signed [31:0] p, input logic signed [31:0] v);
		cmd_t c;
		c.func          = FUNC_LOAD;
		c.load_position = p;
		c.load_velocity = v;
		return c;
	endfunction

	// advance carries junk in the load fields, which the block must ignore
	function automatic cmd_t advance_cmd();
		cmd_t c;
		c.func          = FUNC_ADVANCE;
		c.load_position = $urandom;
		c.load_velocity = $urandom;
		return c;
	endfunction

	// driver: bursts of transfers separated by random gaps
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready)
				expected_states.push_back(next_state(cmd));
			if (cmd_valid && !cmd_ready) begin
				cmd_valid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				cmd       <= cmd_backlog.pop_front();
				cmd_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
				end else begin
					burst_left--;
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern changes at random, plus two long hold-offs
	rx_mode_t rx_mode = RX_OPEN;
	int       mode_left = 0;
	int       hold_left = 0;
	int       holds_taken = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (cmd_backlog.size() > 16 && ((holds_taken == 0 && results_seen >= 300) ||
				(holds_taken == 1 && results_seen >= 1000))) begin
			hold_left = HOLD_CYCLES;
			holds_taken++;
			res_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(8, 80);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_OPEN:   res_ready <= 1'b1;
				RX_COIN:   res_ready <= ($urandom_range(0, 1) == 1);
				default:   res_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// monitor: every result transfer against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (expected_states.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, res);
				errors++;
			end else begin
				want = expected_states.pop_front();
				if (res.position !== want.position) begin
					$display("%0t: position mismatch, expected %h, got %h",
						$time, want.position, res.position);
					errors++;
				end
				if (res.velocity !== want.velocity) begin
					$display("%0t: velocity mismatch, expected %h, got %h",
						$time, want.velocity, res.velocity);
					errors++;
				end
				if (res.saturated !== want.saturated) begin
					$display("%0t: saturated mismatch, expected %b, got %b",
						$time, want.saturated, res.saturated);
					errors++;
				end
			end
		end
	end

	// checked at the falling edge so that queue pops and valid updates have settled
	task automatic wait_drained();
		@(negedge clk);
		while (cmd_backlog.size() != 0 || cmd_valid || expected_states.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_step(input logic [29:0] h);
		@(posedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= h;
		step_model = h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly runs of advances from a random start, loads mixed in at random
	task automatic queue_random(input int count);
		logic signed [31:0] p, v;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				p = $urandom;
				v = $urandom;
				if ($urandom_range(0, 1) == 0) begin
					p = p >>> $urandom_range(1, 12);
					v = v >>> $urandom_range(1, 12);
				end
				cmd_backlog.push_back(load_cmd(p, v));
			end else begin
				cmd_backlog.push_back(advance_cmd());
			end
		end
	endtask

	logic [29:0] step_list[8];

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset state, range corners and saturation under the reset step size
		cmd_backlog.push_back(advance_cmd());
		cmd_backlog.push_back(advance_cmd());
		cmd_backlog.push_back(load_cmd(32'sh7fffffff, 32'sh7fffffff));
		cmd_backlog.push_back(advance_cmd());
		cmd_backlog.push_back(load_cmd(32'sh80000000, 32'sh80000000));
		cmd_backlog.push_back(advance_cmd());
		cmd_backlog.push_back(load_cmd(32'sh80000000, 32'sh7fffffff));
		cmd_backlog.push_back(advance_cmd());
		cmd_backlog.push_back(load_cmd(32'sh7fffffff, 32'sh80000000));
		cmd_backlog.push_back(advance_cmd());
		cmd_backlog.push_back(load_cmd(32'sd0, 32'sd0));
		cmd_backlog.push_back(advance_cmd());
		cmd_backlog.push_back(load_cmd(-32'sd1, 32'sd1));
		cmd_backlog.push_back(advance_cmd());
		cmd_backlog.push_back(load_cmd(32'sd1 <<< FRAC, 32'sd0));
		cmd_backlog.push_back(advance_cmd());
		cmd_backlog.push_back(advance_cmd());
		cmd_backlog.push_back(load_cmd(-(32'sd3 <<< (FRAC - 1)), 32'sh5555aaaa));
		cmd_backlog.push_back(advance_cmd());
		wait_drained();

		step_list[0] = 30'd0;
		step_list[1] = 30'd1;
		step_list[2] = 30'd1 << FRAC;
		step_list[3] = 30'h3fffffff;
		step_list[4] = STEP_RESET;
		step_list[5] = 30'($urandom_range(0, 1 << FRAC));
		step_list[6] = 30'($urandom_range(0, 1 << FRAC));
		step_list[7] = 30'($urandom);
		foreach (step_list[i]) begin
			write_step(step_list[i]);
			queue_random(205);
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && expected_states.size() == 0)
			$display("rk4_harmonic_oscillator_step_tb passed");
		else
			$display("rk4_harmonic_oscillator_step_tb failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("rk4_harmonic_oscillator_step_tb failed");
		$finish;
	end

endmodule

[rk4_harmonic_oscillator_step.f]
sv/rk4h_pkg.sv
sv/rk4h_dp.sv
sv/rk4_harmonic_oscillator_step.sv
tb/rk4_harmonic_oscillator_step_tb.sv
